FILE: rtl/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
`default_nettype none
package fpa_pkg;

	localparam int FracBitsDefault = 8;
	localparam int DataW = 32;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_INC      = 4'd4,
		OP_DEC      = 4'd5,
		OP_MIN      = 4'd6,
		OP_MAX      = 4'd7,
		OP_CMP      = 4'd8,
		OP_FROM_INT = 4'd9,
		OP_TO_INT   = 4'd10
	} op_t;

	// Side information that rides along the divider chain with each request.
	typedef struct packed {
		logic             valid;
		logic             is_div;
		logic             is_mul;
		logic             neg;
		logic             dz;
		logic             gt;
		logic             lt;
		logic             eq;
		logic [DataW-1:0] alt;
	} tag_t;

endpackage
`default_nettype wire

FILE: rtl/fpa_div_cell.sv
// One restoring-division step: develops one quotient bit per cycle while enabled.
`default_nettype none
module fpa_div_cell import fpa_pkg::*; #(
	parameter int QW = 40
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire tag_t             tag_i,
	input  wire logic [DataW-1:0] rem_i,
	input  wire logic [DataW-1:0] den_i,
	input  wire logic [QW-1:0]    nq_i,
	output tag_t                  tag_q,
	output logic      [DataW-1:0] rem_q,
	output logic      [DataW-1:0] den_q,
	output logic      [QW-1:0]    nq_q
);

	logic [DataW:0]   rem_sh;
	logic [DataW:0]   diff;
	logic             fits;

	// Shift in the next dividend bit and try the subtract
	assign rem_sh = {rem_i, nq_i[QW-1]};
	assign diff   = rem_sh - {1'b0, den_i};
	assign fits   = !diff[DataW];

	// Advance the request tag, cleared under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_i;
		end
	end

	// Advance payload to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q        <= fits ? diff[DataW-1:0] : rem_sh[DataW-1:0];
			den_q        <= den_i;
			nq_q         <= {nq_i[QW-2:0], fits};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/fixed_point_q24_8_alu.sv
// Top level of the signed fixed-point ALU with a pipelined divider chain.
//
//  channel | dir | fields (low bit up)
//  s_*     | in  | tuser: operation[3:0]; tdata: operand_a[31:0], operand_b[63:32]
//  m_*     | out | tdata: result[31:0], greater, less, equal, div_by_zero, zero fill
//
// The pipeline is one entry stage with the multiplier, one divider cell per
// quotient bit (32 + FRAC_BITS cells), and the output register. A new request
// is taken every cycle unless the pipeline is stalled.
// The whole pipeline advances together; it stalls only when the output
// register is full and m_tready is low. Reset clears the valid bits.
`default_nettype none
module fixed_point_q24_8_alu import fpa_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // operand_a, operand_b
	input  wire logic [3:0]  s_tuser,   // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata    // result, greater, less, equal, div_by_zero, 0
);

	localparam int QW = DataW + FRAC_BITS;

	logic                    adv;
	logic signed [DataW-1:0] a;
	logic signed [DataW-1:0] b;
	op_t                     op;
	logic [DataW-1:0]        mag_a;
	logic [DataW-1:0]        mag_b;
	logic [DataW-1:0]        alt;
	logic                    dz;

	tag_t                    tag_s1;
	logic [2*DataW-1:0]      prod_s1;
	logic [DataW-1:0]        den_s1;
	logic [QW-1:0]           nq_s1;

	tag_t                    tag_c [QW+1];
	logic [DataW-1:0]        rem_c [QW+1];
	logic [DataW-1:0]        den_c [QW+1];
	logic [QW-1:0]           nq_c  [QW+1];

	logic [DataW-1:0]        quot;
	logic [DataW-1:0]        fin;
	logic                    m_tvalid_q;
	logic [39:0]             m_tdata_q;

	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign a        = signed'(s_tdata[31:0]);
	assign b        = signed'(s_tdata[63:32]);
	assign op       = op_t'(s_tuser);
	assign mag_a    = a[DataW-1] ? DataW'(-a) : DataW'(a);
	assign mag_b    = b[DataW-1] ? DataW'(-b) : DataW'(b);
	assign dz       = (op == OP_DIV) && (b == '0);

	// Select the result of the operations that skip the multiplier and divider
	always_comb begin
		case (op)
			OP_ADD:      alt = DataW'(a + b);
			OP_SUB:      alt = DataW'(a - b);
			OP_DIV:      alt = a;
			OP_INC:      alt = DataW'(a + 1);
			OP_DEC:      alt = DataW'(a - 1);
			OP_MIN:      alt = (a < b) ? a : b;
			OP_MAX:      alt = (a > b) ? a : b;
			OP_FROM_INT: alt = a << FRAC_BITS;
			OP_TO_INT:   alt = a >>> FRAC_BITS;
			default:     alt = '0;
		endcase
	end

	// Entry stage tag: decode and compare, cleared under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.valid  <= s_tvalid;
			tag_s1.is_div <= (op == OP_DIV) && !dz;
			tag_s1.is_mul <= (op == OP_MUL);
			tag_s1.neg    <= a[DataW-1] ^ b[DataW-1];
			tag_s1.dz     <= dz;
			tag_s1.gt     <= a > b;
			tag_s1.lt     <= a < b;
			tag_s1.eq     <= a == b;
			tag_s1.alt    <= alt;
		end
	end

	// Entry stage: multiply, set up the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1       <= 64'(a * b);
			den_s1        <= mag_b;
			nq_s1         <= {mag_a, FRAC_BITS'(0)};
		end
	end

	// Feed the chain, folding in the shifted product
	always_comb begin
		tag_c[0]        = tag_s1;
		tag_c[0].alt    = tag_s1.is_mul ? prod_s1[FRAC_BITS+DataW-1:FRAC_BITS] : tag_s1.alt;
		tag_c[0].is_mul = 1'b0;
		rem_c[0]        = '0;
		den_c[0]        = den_s1;
		nq_c[0]         = nq_s1;
	end

	for (genvar i = 0; i < QW; i++) begin : g_cell
		fpa_div_cell #(.QW(QW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.tag_i  (tag_c[i]),
			.rem_i  (rem_c[i]),
			.den_i  (den_c[i]),
			.nq_i   (nq_c[i]),
			.tag_q  (tag_c[i+1]),
			.rem_q  (rem_c[i+1]),
			.den_q  (den_c[i+1]),
			.nq_q   (nq_c[i+1])
		);
	end

	// Apply the quotient sign and pick the final value
	assign quot = nq_c[QW][DataW-1:0];
	assign fin  = !tag_c[QW].is_div ? tag_c[QW].alt :
	              tag_c[QW].neg ? DataW'(-quot) : quot;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= tag_c[QW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {4'b0, tag_c[QW].dz, tag_c[QW].eq, tag_c[QW].lt, tag_c[QW].gt, fin};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_one_relation: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tdata[34:32]) == 1)
		else $error("exactly one compare flag expected");
	a_dz_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[35] |-> !m_tdata[34] || m_tdata[31:0] == '0)
		else $error("divide by zero with equal operands must return zero");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready must follow output slot");
`endif

endmodule
`default_nettype wire
